// ----- sv/wfcd_pkg.sv -----
package wfcd_pkg;
  localparam int unsigned NSLOTS = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned PID_W = 10;
  localparam int unsigned SEM_W = 4;
  localparam int unsigned HELD_W = 16;
  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned MAX_SEMS_DEF = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DETECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOP,
    ST_VICTIM,
    ST_EMIT,
    ST_NONE
  } wfcd_state_t;

  // Contents of one table slot as seen by the chain logic.
  typedef struct packed {
    logic              valid;
    logic [PID_W-1:0]  pid;
    logic              waits;
    logic [SEM_W-1:0]  wait_sem;
    logic [HELD_W-1:0] held;
  } wfcd_slot_t;

  // Query broadcast from the control unit down the cell row.
  typedef struct packed {
    logic [PID_W-1:0] cur_pid;
    logic [SEM_W-1:0] sem;
    logic             sem_ok;
  } wfcd_query_t;
endpackage

// ----- sv/wait_for_cycle_detector.sv -----
// Channel  | Ports                                       | Handshake
// input    | in_kind in_slot in_slot_used in_proc_id ... | start & !busy
// result   | out_found out_member_id out_victim_id out_last | out_valid, one cycle
//
// A load beat writes one slot. A detect beat scans slots in order; for each
// waiting starting slot it follows the chain hop by hop, then walks the chain
// members to find the victim and emits one result per chain member. Every hop
// goes through the single shared hop lookup; with no cycle, one empty result.
// Reset clears the slot valid bits and the control state. Results cannot be
// stalled by the receiver; busy stays high until the last result is shown.
module wait_for_cycle_detector
  import wfcd_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned MAX_SEMS  = MAX_SEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_slot_used,
  input  logic [PID_W-1:0]  in_proc_id,
  input  logic              in_waits_on_sem,
  input  logic [SEM_W-1:0]  in_wait_sem,
  input  logic [HELD_W-1:0] in_held_mask,
  output logic              out_valid,
  output logic              out_found,
  output logic [PID_W-1:0]  out_member_id,
  output logic [PID_W-1:0]  out_victim_id,
  output logic              out_last
);
  localparam int unsigned LEN_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned CIDX_W = $clog2(MAX_PROCS);

  wfcd_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] start_r, start_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic [SLOT_W-1:0] vic_r, vic_nxt;
  logic [SLOT_W-1:0] chain_r [MAX_PROCS];
  logic              chain_we;
  logic [CIDX_W-1:0] chain_wa;
  logic [SLOT_W-1:0] chain_wd;
  logic              out_valid_nxt, out_found_nxt, out_last_nxt;
  logic [PID_W-1:0]  out_member_nxt, out_victim_nxt;

  wfcd_slot_t  slots [NSLOTS];
  logic        fnd [NSLOTS+1];
  logic [SLOT_W-1:0] fidx [NSLOTS+1];
  logic        ld_en;
  wfcd_slot_t  ld_data;
  logic [NSLOTS-1:0] clr_vec;
  wfcd_query_t query;
  logic        start_holds;
  wfcd_slot_t  cur_s, start_s, hold_s;
  logic [SLOT_W-1:0] cslot;

  assign ld_en = start && !busy && (in_kind == KIND_LOAD);
  assign ld_data = '{valid: in_slot_used, pid: in_proc_id, waits: in_waits_on_sem,
                     wait_sem: in_wait_sem, held: in_held_mask};

  assign cur_s   = slots[cur_r];
  assign start_s = slots[start_r];
  assign query.cur_pid = cur_s.pid;
  assign query.sem     = cur_s.wait_sem;
  assign query.sem_ok  = ({{(32-SEM_W){1'b0}}, cur_s.wait_sem} < 32'(MAX_SEMS));

  assign fnd[0]  = 1'b0;
  assign fidx[0] = '0;

  for (genvar g = 0; g < NSLOTS; g++) begin : g_cell
    wfcd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (ld_en && (in_slot == SLOT_W'(g))),
      .wr_data   (ld_data),
      .clr_valid (clr_vec[g]),
      .query     (query),
      .found_in  (fnd[g]),
      .idx_in    (fidx[g]),
      .my_idx    (SLOT_W'(g)),
      .found_out (fnd[g+1]),
      .idx_out   (fidx[g+1]),
      .slot      (slots[g])
    );
  end

  // Does the starting process hold what the new holder waits on?
  assign hold_s = slots[fidx[NSLOTS]];
  assign start_holds = ({{(32-SEM_W){1'b0}}, hold_s.wait_sem} < 32'(MAX_SEMS))
                       && start_s.held[hold_s.wait_sem];

  assign cslot = chain_r[k_r[CIDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (chain_we) chain_r[chain_wa] <= chain_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= out_valid_nxt;
    end
    start_r <= start_nxt;
    cur_r   <= cur_nxt;
    len_r   <= len_nxt;
    k_r     <= k_nxt;
    vic_r   <= vic_nxt;
    out_found     <= out_found_nxt;
    out_member_id <= out_member_nxt;
    out_victim_id <= out_victim_nxt;
    out_last      <= out_last_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    vic_nxt   = vic_r;
    chain_we  = 1'b0;
    chain_wa  = len_r[CIDX_W-1:0];
    chain_wd  = cur_r;
    clr_vec   = '0;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found;
    out_member_nxt = out_member_id;
    out_victim_nxt = out_victim_id;
    out_last_nxt   = out_last;
    case (state_r)
      ST_IDLE: begin
        if (start && in_kind == KIND_DETECT) begin
          start_nxt = '0;
          cur_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (start_s.valid && start_s.waits) begin
          // The starting slot always opens the chain.
          chain_we  = 1'b1;
          chain_wa  = '0;
          chain_wd  = start_r;
          len_nxt   = LEN_W'(1);
          cur_nxt   = start_r;
          state_nxt = ST_HOP;
        end else if (start_r == SLOT_W'(NSLOTS - 1)) begin
          state_nxt = ST_NONE;
        end else begin
          start_nxt = start_r + 1'b1;
        end
      end
      ST_HOP: begin
        if (!fnd[NSLOTS] || len_r >= LEN_W'(MAX_PROCS)) begin
          if (start_r == SLOT_W'(NSLOTS - 1)) begin
            state_nxt = ST_NONE;
          end else begin
            start_nxt = start_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end else begin
          chain_we = 1'b1;
          chain_wd = fidx[NSLOTS];
          len_nxt  = len_r + 1'b1;
          cur_nxt  = fidx[NSLOTS];
          if (start_holds) begin
            // Victim search walks the chain from its end toward the front.
            k_nxt     = len_r;
            vic_nxt   = fidx[NSLOTS];
            state_nxt = ST_VICTIM;
          end
        end
      end
      ST_VICTIM: begin
        if (k_r == '0) begin
          state_nxt = ST_EMIT;
          clr_vec[vic_r] = 1'b1;
        end else begin
          k_nxt = k_r - 1'b1;
          if (slots[chain_r[k_nxt[CIDX_W-1:0]]].pid > slots[vic_r].pid)
            vic_nxt = chain_r[k_nxt[CIDX_W-1:0]];
        end
      end
      ST_EMIT: begin
        // The pid table still holds the victim's id after its valid bit drops.
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b1;
        out_member_nxt = slots[cslot].pid;
        out_victim_nxt = slots[vic_r].pid;
        out_last_nxt   = (k_r + 1'b1 == len_r);
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == len_r) state_nxt = ST_IDLE;
      end
      ST_NONE: begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b0;
        out_member_nxt = '0;
        out_victim_nxt = '0;
        out_last_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- sv/wfcd_cell.sv -----
module wfcd_cell
  import wfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  wfcd_slot_t  wr_data,
  input  logic        clr_valid,
  input  wfcd_query_t query,
  input  logic        found_in,
  input  logic [SLOT_W-1:0] idx_in,
  input  logic [SLOT_W-1:0] my_idx,
  output logic        found_out,
  output logic [SLOT_W-1:0] idx_out,
  output wfcd_slot_t  slot
);
  logic              valid_r;
  logic [PID_W-1:0]  pid_r;
  logic              waits_r;
  logic [SEM_W-1:0]  sem_r;
  logic [HELD_W-1:0] held_r;
  logic              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= wr_data.valid;
    end else if (clr_valid) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pid_r   <= wr_data.pid;
      waits_r <= wr_data.waits;
      sem_r   <= wr_data.wait_sem;
      held_r  <= wr_data.held;
    end
  end

  assign slot = '{valid: valid_r, pid: pid_r, waits: waits_r, wait_sem: sem_r, held: held_r};

  // A cell answers when it is valid, waits, has another id and holds the queried semaphore.
  assign hit = valid_r && waits_r && (pid_r != query.cur_pid) && query.sem_ok
               && held_r[query.sem];

  // The lowest matching slot wins; later cells pass the earlier answer on.
  assign found_out = found_in || hit;
  assign idx_out   = found_in ? idx_in : my_idx;
endmodule

// ----- sv/wfcd_checker.sv -----
module wfcd_checker
  import wfcd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_valid,
  input logic             out_found,
  input logic [PID_W-1:0] out_member_id,
  input logic [PID_W-1:0] out_victim_id,
  input logic             out_last
);
  a_no_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_member_id == '0 && out_victim_id == '0)
    else $error("empty result carries data");

  a_victim_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_member_id <= out_victim_id)
    else $error("member above victim");

  a_victim_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_victim_id == $past(out_victim_id))
    else $error("victim changed within a run");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy after last beat");
endmodule

bind wait_for_cycle_detector wfcd_checker u_wfcd_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_found(out_found), .out_member_id(out_member_id),
  .out_victim_id(out_victim_id), .out_last(out_last)
);
